@@ rtl/rpfl_pkg.sv @@
package rpfl_pkg;

    // pool geometry defaults
    localparam int MAX_PAGES_DEF  = 32768;
    localparam int PAGE_BYTES_DEF = 4096;

    // field widths
    localparam int ADDR_W    = 32;
    localparam int COUNT_W   = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 32;

    // configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_START = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_LIMIT = 1'd1;
    localparam logic [CFG_W-1:0]     REGION_START_RST = 32'h8000_0000;
    localparam logic [CFG_W-1:0]     REGION_LIMIT_RST = 32'h8800_0000;

    // request operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [2:0] {
        ST_ALLOC      = 3'd0,
        ST_OOM        = 3'd1,
        ST_RETURNED   = 3'd2,
        ST_REFERENCED = 3'd3,
        ST_BAD        = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        FSM_CLEAR,
        FSM_IDLE,
        FSM_EXEC,
        FSM_HOLD
    } fsm_t;

endpackage

@@ rtl/rpfl_req_if.sv @@
interface rpfl_req_if;
    logic                          valid;
    logic                          ready;
    logic                          operation;
    logic [rpfl_pkg::ADDR_W-1:0]   page_address;

    modport source (output valid, output operation, output page_address, input ready);
    modport sink (input valid, input operation, input page_address, output ready);
endinterface

@@ rtl/rpfl_rsp_if.sv @@
interface rpfl_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [rpfl_pkg::ADDR_W-1:0]   granted_address;
    rpfl_pkg::status_t             status;

    modport source (output valid, output granted_address, output status, input ready);
    modport sink (input valid, input granted_address, input status, output ready);
endinterface

@@ rtl/rpfl_addr_check.sv @@
module rpfl_addr_check #(
    parameter int MAX_PAGES  = rpfl_pkg::MAX_PAGES_DEF,
    parameter int PAGE_BYTES = rpfl_pkg::PAGE_BYTES_DEF
) (
    input  logic [rpfl_pkg::ADDR_W-1:0]  page_address,
    input  logic [rpfl_pkg::CFG_W-1:0]   region_start,
    input  logic [rpfl_pkg::CFG_W-1:0]   region_limit,
    output logic                         bad,
    output logic [$clog2(MAX_PAGES)-1:0] idx
);

    localparam int IDX_W    = $clog2(MAX_PAGES);
    localparam int PB_SHIFT = $clog2(PAGE_BYTES);
    localparam int PNUM_W   = rpfl_pkg::ADDR_W - PB_SHIFT;

    logic [rpfl_pkg::ADDR_W-1:0] offset;
    logic [PNUM_W-1:0]           page_num;
    logic                        misaligned;
    logic                        out_of_range;

    // offset into the pool and page number
    assign offset   = page_address - region_start;
    assign page_num = offset[rpfl_pkg::ADDR_W-1:PB_SHIFT];
    assign idx      = IDX_W'(page_num);

    // alignment, window and pool size checks
    assign misaligned   = page_address[PB_SHIFT-1:0] != '0;
    assign out_of_range = (page_address < region_start) || (page_address >= region_limit);
    assign bad = misaligned || out_of_range
              || (32'(page_num) >= 32'(MAX_PAGES));

endmodule

@@ rtl/refcounted_page_free_list.sv @@
// an accepted request runs in EXEC; its result goes to the output register, or to the
//   hold slot while that register is occupied; the per-page count and link memories are
//   read, then written back, and one request is in flight at a time
// reset: config registers take their defaults, the free list is empty, and a clearing
//   pass zeroes all MAX_PAGES count memory entries (32768 by default) with ready low
module refcounted_page_free_list #(
    parameter int MAX_PAGES  = rpfl_pkg::MAX_PAGES_DEF,
    parameter int PAGE_BYTES = rpfl_pkg::PAGE_BYTES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    rpfl_req_if.sink                         req,
    rpfl_rsp_if.source                       rsp,
    input  logic                             cfg_we,
    input  logic [rpfl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rpfl_pkg::CFG_W-1:0]       cfg_data
);

    localparam int IDX_W    = $clog2(MAX_PAGES);
    localparam int PB_SHIFT = $clog2(PAGE_BYTES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_PAGES - 1);

    // configuration
    logic [rpfl_pkg::CFG_W-1:0] region_start_reg;
    logic [rpfl_pkg::CFG_W-1:0] region_limit_reg;

    // control state
    rpfl_pkg::fsm_t    state_reg, state_next;
    logic [IDX_W-1:0]  clr_cnt_reg;
    logic [IDX_W-1:0]  head_reg, head_next;
    logic              empty_reg, empty_next;

    // request in flight
    logic              op_reg;
    logic              bad_reg;
    logic [IDX_W-1:0]  idx_reg;

    // memories and registered read data
    logic [rpfl_pkg::COUNT_W-1:0] ref_mem [MAX_PAGES];
    logic [IDX_W:0]               link_mem [MAX_PAGES];
    logic [rpfl_pkg::COUNT_W-1:0] ref_rdata_reg;
    logic [IDX_W:0]               link_rdata_reg;

    // output register and hold slot
    logic                         out_valid_reg;
    logic [rpfl_pkg::ADDR_W-1:0]  out_addr_reg;
    rpfl_pkg::status_t            out_status_reg;
    logic [rpfl_pkg::ADDR_W-1:0]  hold_addr_reg;
    rpfl_pkg::status_t            hold_status_reg;

    // combinational
    logic                         accept;
    logic                         clearing;
    logic                         exec_act;
    logic                         hold_act;
    logic                         out_free;
    logic                         chk_bad;
    logic [IDX_W-1:0]             chk_idx;
    logic [IDX_W-1:0]             rd_addr;
    logic [rpfl_pkg::COUNT_W-1:0] cnt_dec;
    logic                         pop_now;
    logic                         push_now;
    logic                         ref_we;
    logic [IDX_W-1:0]             ref_waddr;
    logic [rpfl_pkg::COUNT_W-1:0] ref_wdata;
    logic [63:0]                  page_offset;
    logic [rpfl_pkg::ADDR_W-1:0]  res_addr;
    rpfl_pkg::status_t            res_status;

    // free address check
    rpfl_addr_check #(
        .MAX_PAGES  (MAX_PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_check (
        .page_address (req.page_address),
        .region_start (region_start_reg),
        .region_limit (region_limit_reg),
        .bad          (chk_bad),
        .idx          (chk_idx)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_start_reg <= rpfl_pkg::REGION_START_RST;
            region_limit_reg <= rpfl_pkg::REGION_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rpfl_pkg::CFG_REGION_START: region_start_reg <= cfg_data;
                rpfl_pkg::CFG_REGION_LIMIT: region_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rpfl_pkg::FSM_CLEAR:
            begin
                if (clr_cnt_reg == LAST_IDX)
                    state_next = rpfl_pkg::FSM_IDLE;
            end
            rpfl_pkg::FSM_IDLE:
            begin
                if (req.valid)
                    state_next = rpfl_pkg::FSM_EXEC;
            end
            rpfl_pkg::FSM_EXEC:
            begin
                state_next = out_free ? rpfl_pkg::FSM_IDLE : rpfl_pkg::FSM_HOLD;
            end
            rpfl_pkg::FSM_HOLD:
            begin
                if (out_free)
                    state_next = rpfl_pkg::FSM_IDLE;
            end
            default: state_next = rpfl_pkg::FSM_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        clearing = 1'b0;
        exec_act = 1'b0;
        hold_act = 1'b0;
        case (state_reg)
            rpfl_pkg::FSM_CLEAR: clearing = 1'b1;
            rpfl_pkg::FSM_EXEC:  exec_act = 1'b1;
            rpfl_pkg::FSM_HOLD:  hold_act = 1'b1;
            default: ;
        endcase
    end

    assign req.ready = (state_reg == rpfl_pkg::FSM_IDLE);
    assign accept    = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;

    // read address: the page to free, or the list head on allocate
    assign rd_addr = (req.operation == rpfl_pkg::OP_FREE) ? chk_idx : head_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= rpfl_pkg::FSM_CLEAR;
            clr_cnt_reg <= '0;
            head_reg    <= '0;
            empty_reg   <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            empty_reg <= empty_next;
            if (clearing)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // capture the request
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= req.operation;
            bad_reg <= chk_bad;
            idx_reg <= chk_idx;
        end
    end

    // read-modify-write decisions
    always_comb
    begin
        cnt_dec  = (ref_rdata_reg != '0) ? ref_rdata_reg - 1'b1 : '0;
        pop_now  = exec_act && (op_reg == rpfl_pkg::OP_ALLOC) && !empty_reg;
        push_now = exec_act && (op_reg == rpfl_pkg::OP_FREE) && !bad_reg && (cnt_dec == '0);
    end

    // list head update
    always_comb
    begin
        head_next  = head_reg;
        empty_next = empty_reg;
        if (pop_now)
        begin
            if (link_rdata_reg[IDX_W])
                empty_next = 1'b1;
            else
                head_next = link_rdata_reg[IDX_W-1:0];
        end
        else if (push_now)
        begin
            head_next  = idx_reg;
            empty_next = 1'b0;
        end
    end

    // count memory write port
    always_comb
    begin
        ref_we    = 1'b0;
        ref_waddr = idx_reg;
        ref_wdata = cnt_dec;
        if (clearing)
        begin
            ref_we    = 1'b1;
            ref_waddr = clr_cnt_reg;
            ref_wdata = '0;
        end
        else if (pop_now)
        begin
            ref_we    = 1'b1;
            ref_waddr = head_reg;
            ref_wdata = rpfl_pkg::COUNT_W'(1);
        end
        else if (exec_act && (op_reg == rpfl_pkg::OP_FREE) && !bad_reg)
        begin
            ref_we = 1'b1;
        end
    end

    // count memory
    always_ff @(posedge clk)
    begin
        if (ref_we)
            ref_mem[ref_waddr] <= ref_wdata;
        if (accept)
            ref_rdata_reg <= ref_mem[rd_addr];
    end

    // link memory: tail mark over next index
    always_ff @(posedge clk)
    begin
        if (push_now)
            link_mem[idx_reg] <= {empty_reg, (empty_reg ? '0 : head_reg)};
        if (accept)
            link_rdata_reg <= link_mem[rd_addr];
    end

    // result of the request
    always_comb
    begin
        page_offset = 64'(head_reg) << PB_SHIFT;
        res_addr    = '0;
        res_status  = rpfl_pkg::ST_BAD;
        if (op_reg == rpfl_pkg::OP_ALLOC)
        begin
            if (empty_reg)
                res_status = rpfl_pkg::ST_OOM;
            else
            begin
                res_status = rpfl_pkg::ST_ALLOC;
                res_addr   = region_start_reg + page_offset[rpfl_pkg::ADDR_W-1:0];
            end
        end
        else if (!bad_reg)
        begin
            res_status = (cnt_dec == '0) ? rpfl_pkg::ST_RETURNED : rpfl_pkg::ST_REFERENCED;
        end
    end

    // hold slot when the output register is still occupied
    always_ff @(posedge clk)
    begin
        if (exec_act && !out_free)
        begin
            hold_addr_reg   <= res_addr;
            hold_status_reg <= res_status;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if ((exec_act || hold_act) && out_free)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (exec_act && out_free)
        begin
            out_addr_reg   <= res_addr;
            out_status_reg <= res_status;
        end
        else if (hold_act && out_free)
        begin
            out_addr_reg   <= hold_addr_reg;
            out_status_reg <= hold_status_reg;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.granted_address = out_addr_reg;
    assign rsp.status          = out_status_reg;

    // every accepted request is executed in the next cycle
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == rpfl_pkg::FSM_EXEC))
        else $error("accepted request not executed");

    // a page pushed on the list leaves it non-empty with that page on top
    a_push_head: assert property (@(posedge clk) disable iff (!rst_n)
        push_now |=> (!empty_reg && (head_reg == $past(idx_reg))))
        else $error("push did not update list head");

    // only a granted page carries a nonzero address
    a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status != rpfl_pkg::ST_ALLOC)) |-> (rsp.granted_address == '0))
        else $error("nonzero address on a non-allocate result");

    // no request taken during the clearing pass
    a_clear_block: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !req.ready)
        else $error("request taken while clearing counts");

endmodule
